[rtl/rte_pkg.sv]
// Route table engine package: sizes, codes, payload and token types,
// and the reserved-entry check. No dependencies.
package rte_pkg;

  localparam int TABLE_DEPTH    = 16;
  localparam int RESERVED_COUNT = 4;
  localparam int RESERVED_REGS  = 4;
  localparam int ADDR_BITS      = 8;
  localparam int COST_BITS      = 4;
  localparam int ENTRY_W        = 2 * ADDR_BITS + COST_BITS;
  localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_OUT_W    = 5;
  localparam int RSV_W          = 20;
  localparam int APB_AW         = 5;
  localparam int REG_IDX_W      = APB_AW - 2;
  localparam int APB_DW         = 32;

  localparam logic [COST_BITS-1:0] COST_UNREACHABLE = '1;

  localparam logic [REG_IDX_W-1:0] REG_RSV0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RSV1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RSV2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RSV3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OVR  = 3'd5;

  localparam logic [1:0] MODE_ADDR  = 2'd0;
  localparam logic [1:0] MODE_HOP   = 2'd1;
  localparam logic [1:0] MODE_EXACT = 2'd2;

  typedef enum logic [1:0] {
    K_ADD    = 2'd0,
    K_REMOVE = 2'd1,
    K_UPDATE = 2'd2,
    K_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_RSV_ENTRY = 3'd1,
    STAT_RSV_ADDR  = 3'd2,
    STAT_RSV_HOP   = 3'd3,
    STAT_COST      = 3'd4,
    STAT_NOT_FOUND = 3'd5,
    STAT_FULL      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    M_ADDR  = 2'd0,
    M_HOP   = 2'd1,
    M_EXACT = 2'd2
  } match_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_HOLD = 2'd2
  } state_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] hop;
    logic [COST_BITS-1:0] cost;
  } entry_t;

  typedef struct packed {
    kind_e                kind;
    logic [ADDR_BITS-1:0] dest_address;
    logic [ADDR_BITS-1:0] next_hop;
    logic [COST_BITS-1:0] route_cost;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [RESERVED_REGS-1:0][RSV_W-1:0] rsv;
    logic [1:0]                          mode;
    logic                                ovr;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    kind_e            op;
    match_e           mtch;
    logic             ovr;
    entry_t           ent;
    logic [CNT_W-1:0] rem;
    logic             hit;
    logic             done;
    entry_t           last;
  } tok_t;

  typedef struct packed {
    logic   en;
    entry_t data;
  } fill_t;

  function automatic status_e check_entry(entry_t e,
                                          logic [RESERVED_REGS-1:0][RSV_W-1:0] rsv);
    status_e s;
    entry_t  r;
    logic    found;
    s     = STAT_OK;
    found = 1'b0;
    for (int j = 0; j < RESERVED_COUNT; j++) begin
      r = entry_t'(rsv[j][ENTRY_W-1:0]);
      if (!found) begin
        if (r == e) begin
          s     = STAT_RSV_ENTRY;
          found = 1'b1;
        end else if (e.addr == r.addr) begin
          s     = STAT_RSV_ADDR;
          found = 1'b1;
        end else if (e.hop == r.addr) begin
          s     = STAT_RSV_HOP;
          found = 1'b1;
        end
      end
    end
    if (!found && e.cost == COST_UNREACHABLE) begin
      s = STAT_COST;
    end
    return s;
  endfunction

endpackage

[rtl/rte_cell.sv]
// One table cell: holds a route entry, acts on the search token passing
// through and hands it to the next cell. Depends on rte_pkg.
module rte_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rte_pkg::tok_t  tok_i,
  input  rte_pkg::fill_t fill_i,
  output rte_pkg::tok_t  tok_o,
  output logic           hole_o
);
  import rte_pkg::*;

  entry_t entry_q, entry_d;
  tok_t   tok_q, tok_d;
  logic   hole_q, hole_d;
  logic   live, match, first, append, wr;

  always_comb begin
    live = (tok_i.rem != '0);
    case (tok_i.mtch)
      M_ADDR:  match = (entry_q.addr == tok_i.ent.addr);
      M_HOP:   match = (entry_q.hop == tok_i.ent.hop);
      default: match = (entry_q == tok_i.ent);
    endcase
    first  = tok_i.valid && live && match && !tok_i.hit;
    append = tok_i.valid && (tok_i.op == K_ADD) && !live && !tok_i.hit && !tok_i.done;
    wr     = append || (first && (((tok_i.op == K_ADD) && tok_i.ovr) ||
                                  (tok_i.op == K_UPDATE)));

    entry_d = entry_q;
    hole_d  = hole_q;
    if (wr) begin
      entry_d = tok_i.ent;
    end
    if (first && tok_i.op == K_REMOVE) begin
      hole_d = 1'b1;
    end
    if (fill_i.en && hole_q) begin
      entry_d = fill_i.data;
      hole_d  = 1'b0;
    end

    tok_d      = tok_i;
    tok_d.hit  = tok_i.hit | first;
    tok_d.done = tok_i.done | append;
    if (live) begin
      tok_d.rem = tok_i.rem - 1'b1;
      if (tok_i.rem == CNT_W'(1)) begin
        tok_d.last = entry_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      hole_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      hole_q <= hole_d;
    end
  end

  assign tok_o  = tok_q;
  assign hole_o = hole_q;

endmodule

[rtl/rte_ctrl.sv]
// Sequencer: reserved-entry check, token launch, result and count
// update at the end of the cell chain, output register. Depends on rte_pkg.
module rte_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  rte_pkg::req_t               req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output rte_pkg::rsp_t               rsp_o,
  input  rte_pkg::cfg_t               cfg_i,
  output rte_pkg::tok_t               launch_o,
  input  rte_pkg::tok_t               tok_end_i,
  output rte_pkg::fill_t              fill_o,
  output logic [rte_pkg::CNT_W-1:0]   count_o
);
  import rte_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  tok_t             launch_q, launch_d;
  rsp_t             res_q, res_d;
  rsp_t             rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic             accept, out_free;
  entry_t           req_ent;
  status_e          chk;
  match_e           rm_match;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ent     = '{addr: req_i.dest_address, hop: req_i.next_hop,
                         cost: req_i.route_cost};
  assign chk         = check_entry(req_ent, cfg_i.rsv);

  always_comb begin
    case (cfg_i.mode)
      MODE_ADDR: rm_match = M_ADDR;
      MODE_HOP:  rm_match = M_HOP;
      default:   rm_match = M_EXACT;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.kind == K_CLEAR || chk != STAT_OK) begin
            state_d = S_HOLD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tok_end_i.valid) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    launch_d    = '0;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    fill_o      = '{en: 1'b0, data: tok_end_i.last};

    if (state_q == S_IDLE && accept) begin
      if (req_i.kind == K_CLEAR) begin
        count_d = '0;
        res_d   = '{status: STAT_OK, entry_count: '0};
      end else if (chk != STAT_OK) begin
        res_d = '{status: chk, entry_count: COUNT_OUT_W'(count_q)};
      end else begin
        launch_d.valid = 1'b1;
        launch_d.op    = req_i.kind;
        launch_d.mtch  = (req_i.kind == K_REMOVE) ? rm_match : M_ADDR;
        launch_d.ovr   = cfg_i.ovr;
        launch_d.ent   = req_ent;
        launch_d.rem   = count_q;
      end
    end

    if (state_q == S_SCAN && tok_end_i.valid) begin
      res_d = '{status: STAT_OK, entry_count: COUNT_OUT_W'(count_q)};
      case (tok_end_i.op)
        K_ADD: begin
          if (tok_end_i.done) begin
            count_d = CNT_W'(count_q + 1'b1);
          end else if (!tok_end_i.hit) begin
            res_d.status = STAT_FULL;
          end
        end
        K_UPDATE: begin
          if (!tok_end_i.hit) begin
            res_d.status = STAT_NOT_FOUND;
          end
        end
        K_REMOVE: begin
          if (tok_end_i.hit) begin
            count_d   = CNT_W'(count_q - 1'b1);
            fill_o.en = 1'b1;
          end
        end
        default: ;
      endcase
      res_d.entry_count = COUNT_OUT_W'(count_d);
    end

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    if (state_q == S_HOLD && out_free) begin
      rsp_valid_d = 1'b1;
      rsp_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      launch_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      launch_q    <= launch_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign launch_o    = launch_q;
  assign count_o     = count_q;

endmodule

[rtl/routing_table_engine_core.sv]
// Route table engine top level: APB register file, chain of table cells
// and sequencer. Depends on rte_pkg, rte_cell and rte_ctrl.
//
// Route table of TABLE_DEPTH entries (address, next hop, cost), one cell
// per entry. Clear items and items rejected by the reserved-entry or
// cost check finish without a search of the cell chain. Add, remove
// and update send a search token down the cell chain, one cell per
// clock, and no new item is taken until the token has reached the end.
// The result sits in an output register, so the next item is taken at
// once, but that item waits at its end until the earlier result has
// been transferred. A remove moves the last entry into the hole in one
// extra write at the end of the walk. Registers are to be written only
// while the block is idle; the block itself does not enforce this.
module routing_table_engine_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  rte_pkg::req_t                 req_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output rte_pkg::rsp_t                 rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rte_pkg::APB_AW-1:0]    paddr,
  input  logic [rte_pkg::APB_DW-1:0]    pwdata,
  output logic [rte_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import rte_pkg::*;

  logic [RESERVED_REGS-1:0][RSV_W-1:0] rsv_q;
  logic [1:0]                          mode_q;
  logic                                ovr_q;
  logic                                cfg_wr;
  logic [REG_IDX_W-1:0]                reg_idx;
  cfg_t                                cfg;
  tok_t                                tok [TABLE_DEPTH+1];
  fill_t                               fill;
  logic [TABLE_DEPTH-1:0]              hole_vec;
  logic [CNT_W-1:0]                    count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_q  <= '0;
      mode_q <= MODE_EXACT;
      ovr_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RSV0: rsv_q[0] <= pwdata[RSV_W-1:0];
        REG_RSV1: rsv_q[1] <= pwdata[RSV_W-1:0];
        REG_RSV2: rsv_q[2] <= pwdata[RSV_W-1:0];
        REG_RSV3: rsv_q[3] <= pwdata[RSV_W-1:0];
        REG_MODE: mode_q   <= pwdata[1:0];
        REG_OVR:  ovr_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RSV0: prdata = APB_DW'(rsv_q[0]);
      REG_RSV1: prdata = APB_DW'(rsv_q[1]);
      REG_RSV2: prdata = APB_DW'(rsv_q[2]);
      REG_RSV3: prdata = APB_DW'(rsv_q[3]);
      REG_MODE: prdata = APB_DW'(mode_q);
      REG_OVR:  prdata = APB_DW'(ovr_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg = '{rsv: rsv_q, mode: mode_q, ovr: ovr_q};

  rte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_i       (cfg),
    .launch_o    (tok[0]),
    .tok_end_i   (tok[TABLE_DEPTH]),
    .fill_o      (fill),
    .count_o     (count)
  );

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    rte_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[k]),
      .fill_i (fill),
      .tok_o  (tok[k+1]),
      .hole_o (hole_vec[k])
    );
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_one_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hole_vec))
    else $error("more than one pending hole");

  a_busy_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[TABLE_DEPTH].valid |-> !req_ready_o)
    else $error("input ready while a search is in flight");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && req_i.kind == K_CLEAR) |=> (count == '0))
    else $error("clear did not empty the table");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench for routing_table_engine_core: route add/remove/update/clear transfers
// and APB register writes, with every response predicted and checked in the bench.
// Depends on rte_pkg and the routing_table_engine_core RTL.
module tb;
  import rte_pkg::*;

  localparam int         SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int         REQ_W         = $bits(req_t);
  localparam int         PHASE_ITEMS   = 75;
  localparam logic [1:0] MODE_SPARE    = 2'd3;  // decodes as exact match

  logic                  clk_i;
  logic                  rst_ni;
  logic                  req_valid_i;
  logic                  req_ready_o;
  req_t                  req_i;
  logic                  rsp_valid_o;
  logic                  rsp_ready_i;
  rsp_t                  rsp_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  routing_table_engine_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // bench copy of the table and its settings
  entry_t           route_tbl [TABLE_DEPTH];
  int               route_cnt;
  logic [RSV_W-1:0] rsv_copy [RESERVED_REGS];
  logic [1:0]       rm_mode;
  logic             ovr_en;
  rsp_t             route_rsp_q [$];

  int errors;
  int items_sent;
  int rsp_seen;
  int cfg_writes;
  int hold_left;
  bit burst;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    errors++;
  endtask

  function automatic req_t route_req(kind_e k, logic [7:0] a, logic [7:0] h, logic [3:0] c);
    req_t r;
    r.kind         = k;
    r.dest_address = a;
    r.next_hop     = h;
    r.route_cost   = c;
    return r;
  endfunction

  function automatic int find_route(logic [ADDR_BITS-1:0] a);
    for (int i = 0; i < route_cnt; i++) begin
      if (route_tbl[i].addr == a) return i;
    end
    return -1;
  endfunction

  function automatic rsp_t apply_route_op(req_t it);
    entry_t  e;
    entry_t  r;
    status_e st;
    int      idx;
    bit      hit;
    rsp_t    res;
    e.addr = it.dest_address;
    e.hop  = it.next_hop;
    e.cost = it.route_cost;
    st     = STAT_OK;
    idx    = -1;
    if (it.kind == K_CLEAR) begin
      route_cnt = 0;
    end else begin
      for (int j = 0; j < RESERVED_COUNT && st == STAT_OK; j++) begin
        r = entry_t'(rsv_copy[j]);
        if (r == e) st = STAT_RSV_ENTRY;
        else if (r.addr == e.addr) st = STAT_RSV_ADDR;
        else if (r.addr == e.hop) st = STAT_RSV_HOP;
      end
      if (st == STAT_OK && e.cost == COST_UNREACHABLE) st = STAT_COST;
      if (st == STAT_OK) begin
        case (it.kind)
          K_ADD: begin
            idx = find_route(e.addr);
            if (idx < 0) begin
              if (route_cnt < TABLE_DEPTH) begin
                route_tbl[route_cnt] = e;
                route_cnt++;
              end else begin
                st = STAT_FULL;
              end
            end else if (ovr_en) begin
              route_tbl[idx] = e;
            end
          end
          K_REMOVE: begin
            for (int i = 0; i < route_cnt && idx < 0; i++) begin
              case (rm_mode)
                MODE_ADDR: hit = route_tbl[i].addr == e.addr;
                MODE_HOP:  hit = route_tbl[i].hop == e.hop;
                default:   hit = route_tbl[i] == e;
              endcase
              if (hit) idx = i;
            end
            if (idx >= 0) begin
              route_tbl[idx] = route_tbl[route_cnt-1];
              route_cnt--;
            end
          end
          default: begin
            idx = find_route(e.addr);
            if (idx >= 0) route_tbl[idx] = e;
            else st = STAT_NOT_FOUND;
          end
        endcase
      end
    end
    res.status      = st;
    res.entry_count = COUNT_OUT_W'(route_cnt);
    return res;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_item(input req_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_i       <= it;
    req_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    route_rsp_q.push_back(apply_route_op(it));
    items_sent++;
  endtask

  task automatic settle();
    req_valid_i <= 1'b0;
    while (route_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input logic [REG_IDX_W-1:0] idx,
                          input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [APB_DW-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_MODE: return {{(APB_DW-2){1'b0}}, rm_mode};
      REG_OVR:  return {{(APB_DW-1){1'b0}}, ovr_en};
      default:  return {{(APB_DW-RSV_W){1'b0}}, rsv_copy[idx[1:0]]};
    endcase
  endfunction

  task automatic read_check(input logic [REG_IDX_W-1:0] idx);
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx))
      report_error($sformatf("register %0d reads %h, want %h", idx, rd, reg_value(idx)));
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] rd;
    settle();
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_MODE: rm_mode = val[1:0];
      REG_OVR:  ovr_en  = val[0];
      default:  rsv_copy[idx[1:0]] = val[RSV_W-1:0];
    endcase
    cfg_writes++;
    read_check(idx);
  endtask

  task automatic config_all(input logic [RSV_W-1:0] r0, input logic [RSV_W-1:0] r1,
                            input logic [RSV_W-1:0] r2, input logic [RSV_W-1:0] r3,
                            input logic [1:0] mode, input logic ovr);
    write_reg(REG_RSV0, APB_DW'(r0));
    write_reg(REG_RSV1, APB_DW'(r1));
    write_reg(REG_RSV2, APB_DW'(r2));
    write_reg(REG_RSV3, APB_DW'(r3));
    write_reg(REG_MODE, APB_DW'(mode));
    write_reg(REG_OVR, APB_DW'(ovr));
  endtask

  // reset values: every reserved entry is all zero, so address 0 and hop 0 are taken
  task automatic test_reset_defaults();
    read_check(REG_RSV0);
    read_check(REG_RSV1);
    read_check(REG_RSV2);
    read_check(REG_RSV3);
    read_check(REG_MODE);
    read_check(REG_OVR);
    send_item(route_req(K_ADD, 8'h00, 8'h00, 4'h0));
    send_item(route_req(K_ADD, 8'h00, 8'h07, 4'h3));
    send_item(route_req(K_UPDATE, 8'h07, 8'h00, 4'h3));
    send_item(route_req(K_REMOVE, 8'h07, 8'h07, 4'hF));
    send_item(route_req(K_ADD, 8'h07, 8'h08, 4'h2));
    send_item(route_req(K_CLEAR, 8'h07, 8'h08, 4'h2));
  endtask

  task automatic test_checks_and_capacity();
    config_all(20'hFFFFF, {8'h10, 8'h20, 4'h3}, {8'h80, 8'h01, 4'h0},
               {8'hC0, 8'hC0, 4'hE}, MODE_ADDR, 1'b0);
    send_item(route_req(K_ADD, 8'hFF, 8'hFF, 4'hF));
    send_item(route_req(K_ADD, 8'hFF, 8'h00, 4'h0));
    send_item(route_req(K_ADD, 8'h01, 8'hFF, 4'h0));
    send_item(route_req(K_ADD, 8'h10, 8'hFF, 4'h3));   // first reserved entry wins
    send_item(route_req(K_ADD, 8'h10, 8'h20, 4'h3));
    send_item(route_req(K_UPDATE, 8'h01, 8'h10, 4'h1));
    send_item(route_req(K_ADD, 8'h01, 8'h02, 4'hF));
    send_item(route_req(K_ADD, 8'h00, 8'hFE, 4'h0));
    for (int i = 1; i < TABLE_DEPTH; i++)
      send_item(route_req(K_ADD, 8'h40 + i[7:0], 8'hFE - i[7:0], 4'(i % 15)));
    send_item(route_req(K_ADD, 8'h50, 8'h01, 4'h1));
    send_item(route_req(K_UPDATE, 8'h50, 8'h01, 4'h1));
    send_item(route_req(K_ADD, 8'h41, 8'h02, 4'h2));
    send_item(route_req(K_REMOVE, 8'h43, 8'h00, 4'h0));
    send_item(route_req(K_REMOVE, 8'h99, 8'h00, 4'h0));
    send_item(route_req(K_UPDATE, 8'h41, 8'h00, 4'hE));
    send_item(route_req(K_CLEAR, 8'h00, 8'h00, 4'h0));
  endtask

  task automatic test_match_modes();
    write_reg(REG_OVR, APB_DW'(1));
    send_item(route_req(K_ADD, 8'h21, 8'h22, 4'h1));
    send_item(route_req(K_ADD, 8'h31, 8'h32, 4'h2));
    send_item(route_req(K_ADD, 8'h21, 8'h33, 4'h3));
    write_reg(REG_MODE, APB_DW'(MODE_HOP));
    send_item(route_req(K_REMOVE, 8'h00, 8'h33, 4'h0));
    send_item(route_req(K_REMOVE, 8'h00, 8'h44, 4'h0));
    write_reg(REG_MODE, APB_DW'(MODE_EXACT));
    send_item(route_req(K_ADD, 8'h21, 8'h33, 4'h3));
    send_item(route_req(K_REMOVE, 8'h31, 8'h32, 4'h1));
    send_item(route_req(K_REMOVE, 8'h31, 8'h32, 4'h2));
    write_reg(REG_MODE, APB_DW'(MODE_SPARE));
    send_item(route_req(K_REMOVE, 8'h21, 8'h33, 4'h4));
    send_item(route_req(K_REMOVE, 8'h21, 8'h33, 4'h3));
  endtask

  // response side stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    settle();
    burst     = 1'b1;
    hold_left = 300;
    for (int i = 0; i < 14; i++)
      send_item(route_req(K_ADD, 8'($urandom_range(0, 254)), 8'($urandom_range(0, 254)),
                          4'($urandom_range(0, 14))));
    burst = 1'b0;
    settle();
  endtask

  task automatic test_random();
    int                 pick;
    req_t               it;
    logic [REQ_W-1:0]   raw;
    logic [7:0]         addr_pool [24];
    logic [7:0]         hop_pool [8];
    logic [RSV_W-1:0]   rv [RESERVED_REGS];
    entry_t             pe;
    for (int ph = 0; ph < 6; ph++) begin
      foreach (addr_pool[i]) addr_pool[i] = 8'($urandom());
      foreach (hop_pool[i]) hop_pool[i] = 8'($urandom());
      for (int j = 0; j < RESERVED_REGS; j++) begin
        case (ph)
          0:       rv[j] = '1;
          1:       rv[j] = '0;
          default: rv[j] = ($urandom_range(0, 3) == 0) ?
                           {addr_pool[$urandom_range(0, 23)], 8'($urandom()), 4'($urandom())} :
                           RSV_W'($urandom());
        endcase
      end
      config_all(rv[0], rv[1], rv[2], rv[3], 2'(ph % 4), 1'(ph % 2));
      burst = (ph == 2 || ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          raw = REQ_W'($urandom());
          it  = req_t'(raw);
        end else begin
          pick = $urandom_range(0, 99);
          it.kind = (pick < 45) ? K_ADD : (pick < 70) ? K_REMOVE :
                    (pick < 97) ? K_UPDATE : K_CLEAR;
          it.dest_address = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, 23)] :
                            8'($urandom());
          it.next_hop     = ($urandom_range(0, 99) < 70) ? hop_pool[$urandom_range(0, 7)] :
                            8'($urandom());
          it.route_cost   = ($urandom_range(0, 9) == 0) ? COST_UNREACHABLE :
                            4'($urandom_range(0, 14));
          if (it.kind != K_ADD && route_cnt > 0 && $urandom_range(0, 99) < 40) begin
            pe              = route_tbl[$urandom_range(0, route_cnt - 1)];
            it.dest_address = pe.addr;
            it.next_hop     = pe.hop;
            it.route_cost   = pe.cost;
          end
        end
        send_item(it);
      end
    end
    burst = 1'b0;
  endtask

  initial begin : rsp_side
    int   stall;
    rsp_t want;
    stall = 0;
    rsp_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_valid_o && rsp_ready_i) begin
        rsp_seen++;
        if (route_rsp_q.size() == 0) begin
          report_error($sformatf("response %0d arrived with none outstanding", rsp_seen));
        end else begin
          want = route_rsp_q.pop_front();
          if (rsp_o.status !== want.status)
            report_error($sformatf("response %0d status: got %0d, want %0d",
                                   rsp_seen, rsp_o.status, want.status));
          if (rsp_o.entry_count !== want.entry_count)
            report_error($sformatf("response %0d entry_count: got %0d, want %0d",
                                   rsp_seen, rsp_o.entry_count, want.entry_count));
        end
        stall = burst ? 0 : $urandom_range(0, 9);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("routing_table_engine_core: mismatch");
    $finish;
  end

  initial begin
    errors      = 0;
    items_sent  = 0;
    rsp_seen    = 0;
    cfg_writes  = 0;
    hold_left   = 0;
    burst       = 1'b0;
    route_cnt   = 0;
    rm_mode     = MODE_EXACT;
    ovr_en      = 1'b0;
    foreach (rsv_copy[j]) rsv_copy[j] = '0;
    rst_ni      <= 1'b0;
    req_valid_i <= 1'b0;
    req_i       <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_checks_and_capacity();
    test_match_modes();
    test_backpressure();
    test_random();
    settle();
    $display("Sent %0d route operations, checked %0d responses, %0d register writes.",
             items_sent, rsp_seen, cfg_writes);
    $display("Reserved checks, full table, all remove modes, long stall: %0d errors.",
             errors);
    if (errors == 0) begin
      $display("routing_table_engine_core: match");
    end else begin
      $display("routing_table_engine_core: mismatch");
    end
    $finish;
  end

endmodule
